// ===== src/vpaf_pkg.sv =====
// ----------------------------------------------------------------------------
// vpaf_pkg
// Shared types, constants and helpers for the vibration peak/average framer.
// ----------------------------------------------------------------------------
package vpaf_pkg;

  // Frame layout
  localparam int FRAME_LENGTH    = 7;
  localparam int BYTE_IDX_BITS   = $clog2(FRAME_LENGTH);
  localparam int STORE_IDX_BITS  = $clog2(FRAME_LENGTH - 1);

  // Default widths
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int SUM_BITS_DEF    = 32;

  // Average: (sum >> shift) / 47
  localparam int SHIFT_FIRST     = 7;
  localparam int SHIFT_SECOND    = 8;
  localparam int AVG_DIVISOR     = 47;

  // Reciprocal divide by 47: exact for inputs below 47 * 2^24, quotients above
  // that saturate the scaled byte anyway, so they clamp to all ones.
  localparam int QUOT_BITS       = 24;
  localparam int DIV_IN_BITS     = 30;
  localparam int DIV_SHIFT       = 36;
  localparam int RECIP_BITS      = 31;
  localparam int PROD_BITS       = DIV_IN_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] DIV_RECIP =
    RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'(AVG_DIVISOR - 1)) / 64'(AVG_DIVISOR));
  localparam logic [63:0] DIV_CLAMP = 64'(AVG_DIVISOR) << QUOT_BITS;

  // Gain scaling
  localparam int GAIN_BITS       = 16;
  localparam int SCL_BITS        = QUOT_BITS + GAIN_BITS;

  // Configuration register indexes
  localparam int CFG_IDX_BITS    = 3;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FIRST_PERIOD  = 3'd0;
  localparam cfg_idx_t CFG_SECOND_PERIOD = 3'd1;
  localparam cfg_idx_t CFG_RESEND_GAP    = 3'd2;
  localparam cfg_idx_t CFG_ATTEMPT_LIMIT = 3'd3;
  localparam cfg_idx_t CFG_SYNC_BYTE     = 3'd4;
  localparam cfg_idx_t CFG_GAIN          = 3'd5;

  localparam int CFG_DATA_BITS   = 16;

  // Register reset values
  localparam logic [7:0]  RST_FIRST_PERIOD  = 8'd59;
  localparam logic [7:0]  RST_SECOND_PERIOD = 8'd119;
  localparam logic [6:0]  RST_RESEND_GAP    = 7'd4;
  localparam logic [7:0]  RST_ATTEMPT_LIMIT = 8'd2;
  localparam logic [7:0]  RST_SYNC_BYTE     = 8'd170;
  localparam logic [15:0] RST_GAIN          = 16'd6554;

  // Frame engine states
  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_DIV,
    ENG_SCALE,
    ENG_PACK,
    ENG_SEND
  } eng_state_t;

  // Take the Q0.16 product down to a byte, saturating at 255.
  function automatic logic [7:0] sat_byte(input logic [SCL_BITS-1:0] prod);
    logic [QUOT_BITS-1:0] v;
    v = prod[GAIN_BITS +: QUOT_BITS];
    sat_byte = (|v[QUOT_BITS-1:8]) ? 8'hFF : v[7:0];
  endfunction

endpackage

// ===== src/vibration_peak_average_framer_top.sv =====
// ----------------------------------------------------------------------------
// vibration_peak_average_framer_top
// Folds two-axis samples, tracks peaks and sums per tick period, and sends
// seven-byte frames with resends at the gap ticks.
// ----------------------------------------------------------------------------
// Order: a sample updates peaks and sums in the cycle after its transaction.
// A period-end tick passes the input register, snapshot, divide, scale and
// pack registers and reaches the output as byte 0; a resend tick goes from
// the input register straight to send. Throughput: samples one per cycle while
// no tick is held at the input; a tick waits while a frame is built or sent.
// Reset: synchronous, clears all counters, peaks, sums and handshake state and
// reloads register defaults; the frame store holds nothing until a frame.
module vibration_peak_average_framer_top #(
  parameter int SAMPLE_BITS = vpaf_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = vpaf_pkg::SUM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic [SAMPLE_BITS-1:0]            sample_x,
  input  logic [SAMPLE_BITS-1:0]            sample_y,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        frame_byte,
  output logic                              ninth_bit,
  output logic                              last_byte,
  // Configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  vpaf_pkg::cfg_idx_t                cfg_index,
  input  logic [vpaf_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import vpaf_pkg::*;

  localparam int FOLD_BITS = SAMPLE_BITS - 1;
  localparam int AVG_BITS  = SUM_BITS - SHIFT_FIRST;
  localparam logic [BYTE_IDX_BITS-1:0] LAST_IDX = BYTE_IDX_BITS'(FRAME_LENGTH - 1);

  // Configuration registers
  logic [7:0]  first_period;
  logic [7:0]  second_period;
  logic [6:0]  resend_gap;
  logic [7:0]  attempt_limit;
  logic [7:0]  sync_byte;
  logic [15:0] gain;

  // Input register
  logic                   in_vld;
  logic                   in_mode;
  logic [SAMPLE_BITS-1:0] in_x;
  logic [SAMPLE_BITS-1:0] in_y;
  logic                   advance;
  logic                   tick_go;
  logic                   sample_go;

  // Period state
  logic [7:0]           tick_count;
  logic [7:0]           attempt_count;
  logic                 second_mode;
  logic [FOLD_BITS-1:0] peak_x;
  logic [FOLD_BITS-1:0] peak_y;
  logic [SUM_BITS-1:0]  sum_x;
  logic [SUM_BITS-1:0]  sum_y;

  // Tick decision
  logic [7:0]           tick_inc;
  logic [7:0]           period_limit;
  logic [7:0]           attempt_inc;
  logic                 fire;
  logic                 resend;
  logic                 emit;
  logic [FOLD_BITS-1:0] fold_x;
  logic [FOLD_BITS-1:0] fold_y;

  // Frame build pipeline
  logic [AVG_BITS-1:0]  snap_nx;
  logic [AVG_BITS-1:0]  snap_ny;
  logic [FOLD_BITS-1:0] snap_px;
  logic [FOLD_BITS-1:0] snap_py;
  logic [63:0]          nx_wide;
  logic [63:0]          ny_wide;
  logic [PROD_BITS-1:0] prod_x;
  logic [PROD_BITS-1:0] prod_y;
  logic                 clamp_x;
  logic                 clamp_y;
  logic [FOLD_BITS-1:0] pk_x;
  logic [FOLD_BITS-1:0] pk_y;
  logic [QUOT_BITS-1:0] quot_x;
  logic [QUOT_BITS-1:0] quot_y;
  logic [SCL_BITS-1:0]  scl_ax;
  logic [SCL_BITS-1:0]  scl_px;
  logic [SCL_BITS-1:0]  scl_ay;
  logic [SCL_BITS-1:0]  scl_py;
  logic [7:0]           b1;
  logic [7:0]           b2;
  logic [7:0]           b3;
  logic [7:0]           b4;
  logic [7:0]           frame_store [FRAME_LENGTH-1];

  // Frame engine
  eng_state_t               eng;
  eng_state_t               eng_next;
  logic                     eng_idle;
  logic                     pack_en;
  logic                     send_step;
  logic [BYTE_IDX_BITS-1:0] byte_idx;
  logic [STORE_IDX_BITS-1:0] store_idx;

  // --------------------------------------------------------------------------
  // Configuration: always ready; to be written only while the block is quiet, which the block does not enforce.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_period  <= RST_FIRST_PERIOD;
      second_period <= RST_SECOND_PERIOD;
      resend_gap    <= RST_RESEND_GAP;
      attempt_limit <= RST_ATTEMPT_LIMIT;
      sync_byte     <= RST_SYNC_BYTE;
      gain          <= RST_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_PERIOD:  first_period  <= cfg_data[7:0];
        CFG_SECOND_PERIOD: second_period <= cfg_data[7:0];
        CFG_RESEND_GAP:    resend_gap    <= cfg_data[6:0];
        CFG_ATTEMPT_LIMIT: attempt_limit <= cfg_data[7:0];
        CFG_SYNC_BYTE:     sync_byte     <= cfg_data[7:0];
        CFG_GAIN:          gain          <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. Samples drain every cycle; a tick holds until the frame
  // engine is idle, since it may start a frame or a resend.
  // --------------------------------------------------------------------------
  assign advance   = in_vld && (!in_mode || eng_idle);
  assign in_ready  = !in_vld || advance;
  assign tick_go   = advance && in_mode;
  assign sample_go = advance && !in_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_mode <= mode;
      in_x    <= sample_x;
      in_y    <= sample_y;
    end
  end

  // --------------------------------------------------------------------------
  // Fold around mid-scale: an upper-half reading becomes full scale minus it.
  // --------------------------------------------------------------------------
  assign fold_x = in_x[SAMPLE_BITS-1] ? ~in_x[FOLD_BITS-1:0] : in_x[FOLD_BITS-1:0];
  assign fold_y = in_y[SAMPLE_BITS-1] ? ~in_y[FOLD_BITS-1:0] : in_y[FOLD_BITS-1:0];

  // --------------------------------------------------------------------------
  // Tick decision. The period end wins over a resend; both count an attempt.
  // The resend compare uses twice the gap with no wrap.
  // --------------------------------------------------------------------------
  assign tick_inc     = tick_count + 8'd1;
  assign period_limit = second_mode ? second_period : first_period;
  assign fire         = tick_inc > period_limit;
  assign resend       = !fire && (attempt_count != 8'd0) &&
                        ((tick_inc == {1'b0, resend_gap}) || (tick_inc == {resend_gap, 1'b0}));
  assign emit         = fire || resend;
  assign attempt_inc  = attempt_count + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      attempt_count <= '0;
      second_mode   <= 1'b0;
      peak_x        <= '0;
      peak_y        <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
    end else if (sample_go) begin
      if (fold_x > peak_x) peak_x <= fold_x;
      if (fold_y > peak_y) peak_y <= fold_y;
      sum_x <= sum_x + SUM_BITS'(fold_x);
      sum_y <= sum_y + SUM_BITS'(fold_y);
    end else if (tick_go) begin
      tick_count <= fire ? 8'd0 : tick_inc;
      if (fire) begin
        // Period end: restart the accumulation
        peak_x <= '0;
        peak_y <= '0;
        sum_x  <= '0;
        sum_y  <= '0;
      end
      if (emit) begin
        if (attempt_inc > attempt_limit) begin
          attempt_count <= '0;
          second_mode   <= 1'b1;
        end else begin
          attempt_count <= attempt_inc;
        end
      end
    end
  end

  // Snapshot the period totals; the shift follows the mode before this tick.
  always_ff @(posedge clk) begin
    if (tick_go && fire) begin
      snap_nx <= second_mode ? AVG_BITS'(sum_x >> SHIFT_SECOND) : AVG_BITS'(sum_x >> SHIFT_FIRST);
      snap_ny <= second_mode ? AVG_BITS'(sum_y >> SHIFT_SECOND) : AVG_BITS'(sum_y >> SHIFT_FIRST);
      snap_px <= peak_x;
      snap_py <= peak_y;
    end
  end

  // --------------------------------------------------------------------------
  // Frame build: divide by 47 through a reciprocal multiply, then gain scale,
  // then saturate and pack with the two check bytes.
  // --------------------------------------------------------------------------
  assign nx_wide = 64'(snap_nx);
  assign ny_wide = 64'(snap_ny);

  always_ff @(posedge clk) begin
    prod_x  <= PROD_BITS'(nx_wide[DIV_IN_BITS-1:0]) * PROD_BITS'(DIV_RECIP);
    prod_y  <= PROD_BITS'(ny_wide[DIV_IN_BITS-1:0]) * PROD_BITS'(DIV_RECIP);
    clamp_x <= nx_wide >= DIV_CLAMP;
    clamp_y <= ny_wide >= DIV_CLAMP;
    pk_x    <= snap_px;
    pk_y    <= snap_py;
  end

  assign quot_x = clamp_x ? '1 : prod_x[DIV_SHIFT +: QUOT_BITS];
  assign quot_y = clamp_y ? '1 : prod_y[DIV_SHIFT +: QUOT_BITS];

  always_ff @(posedge clk) begin
    scl_ax <= SCL_BITS'(quot_x) * SCL_BITS'(gain);
    scl_px <= SCL_BITS'(pk_x) * SCL_BITS'(gain);
    scl_ay <= SCL_BITS'(quot_y) * SCL_BITS'(gain);
    scl_py <= SCL_BITS'(pk_y) * SCL_BITS'(gain);
  end

  assign b1 = sat_byte(scl_ax);
  assign b2 = sat_byte(scl_px);
  assign b3 = sat_byte(scl_ay);
  assign b4 = sat_byte(scl_py);

  always_ff @(posedge clk) begin
    if (pack_en) begin
      frame_store[0] <= b1;
      frame_store[1] <= b2;
      frame_store[2] <= b3;
      frame_store[3] <= b4;
      frame_store[4] <= ~(b1 + b2 + b3 + b4);
      frame_store[5] <= ~(b1 ^ b2 ^ b3 ^ b4);
    end
  end

  // --------------------------------------------------------------------------
  // Frame engine: next state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      eng <= ENG_IDLE;
    end else begin
      eng <= eng_next;
    end
  end

  always_comb begin
    eng_next = eng;
    case (eng)
      ENG_IDLE: begin
        if (tick_go && fire) begin
          eng_next = ENG_DIV;
        end else if (tick_go && resend) begin
          eng_next = ENG_SEND;
        end
      end
      ENG_DIV:   eng_next = ENG_SCALE;
      ENG_SCALE: eng_next = ENG_PACK;
      ENG_PACK:  eng_next = ENG_SEND;
      ENG_SEND: begin
        if (send_step && (byte_idx == LAST_IDX)) eng_next = ENG_IDLE;
      end
      default:   eng_next = ENG_IDLE;
    endcase
  end

  // Frame engine: outputs
  always_comb begin
    eng_idle  = 1'b0;
    pack_en   = 1'b0;
    send_step = 1'b0;
    case (eng)
      ENG_IDLE:  eng_idle  = 1'b1;
      ENG_PACK:  pack_en   = 1'b1;
      ENG_SEND:  send_step = !out_valid || out_ready;
      default: ;
    endcase
  end

  // Byte counter: advance on each byte handed to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= '0;
    end else if (send_step) begin
      byte_idx <= (byte_idx == LAST_IDX) ? '0 : byte_idx + BYTE_IDX_BITS'(1);
    end
  end

  assign store_idx = STORE_IDX_BITS'(byte_idx - BYTE_IDX_BITS'(1));

  // --------------------------------------------------------------------------
  // Output register: holds one byte; refills in the cycle it is taken.
  // Byte 0 is always the current sync byte.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (send_step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send_step) begin
      frame_byte <= (byte_idx == '0) ? sync_byte : frame_store[store_idx];
      ninth_bit  <= byte_idx == '0;
      last_byte  <= byte_idx == LAST_IDX;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A tick never advances while a frame is built or sent.
  a_tick_waits: assert property (@(posedge clk) disable iff (rst)
    (eng != ENG_IDLE) |-> !tick_go)
    else $error("tick advanced while frame engine busy");

  // A period end starts the divide stage next cycle.
  a_fire_to_div: assert property (@(posedge clk) disable iff (rst)
    (tick_go && fire) |=> (eng == ENG_DIV))
    else $error("period end did not start frame build");

  // While byte 0 waits on the output, the engine points at byte 1.
  a_first_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ninth_bit) |-> (eng == ENG_SEND && byte_idx == BYTE_IDX_BITS'(1)))
    else $error("sync byte out of step with byte counter");

  // Entering the second period clears the attempt count.
  a_second_mode: assert property (@(posedge clk) disable iff (rst)
    $rose(second_mode) |-> (attempt_count == 8'd0))
    else $error("second period entered with attempts pending");

endmodule

// ===== bench/vibration_peak_average_framer_top_test.sv =====
// ----------------------------------------------------------------------------
// vibration_peak_average_framer_top_test
// Self-checking bench for the peak/average framer. A queue-fed driver presents
// samples and timer ticks, a transaction model predicts every frame byte,
// and a monitor checks each output transaction against the oldest prediction.
// Register settings change between phases, only while the block is quiet.
// ----------------------------------------------------------------------------
module vibration_peak_average_framer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vpaf_pkg::*;

  localparam int SW            = SAMPLE_BITS_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 1000;  // cycles with no transaction at all
  localparam int REPORT_MAX    = 10;

  // Writes to these indexes must be ignored by the block.
  localparam cfg_idx_t CFG_SPARE_6 = 3'd6;
  localparam cfg_idx_t CFG_SPARE_7 = 3'd7;

  typedef enum logic {
    ITEM_SAMPLE = 1'b0,
    ITEM_TICK   = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t    kind;
    logic [SW-1:0] sx;
    logic [SW-1:0] sy;
  } stim_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } frame_beat_t;

  // Clock, reset and block inputs, all known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic [SW-1:0] sample_x = '0;
  logic [SW-1:0] sample_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] frame_byte;
  logic ninth_bit;
  logic last_byte;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Stimulus waiting for the driver, and frame bytes the block still owes us
  stim_item_t  item_queue[$];
  frame_beat_t frame_bytes_due[$];

  // Turn off all idling on both sides while set
  logic steady = 1'b0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  // Register copies, loaded with the block's reset values
  logic [7:0]  r_first_period  = RST_FIRST_PERIOD;
  logic [7:0]  r_second_period = RST_SECOND_PERIOD;
  logic [6:0]  r_resend_gap    = RST_RESEND_GAP;
  logic [7:0]  r_attempt_limit = RST_ATTEMPT_LIMIT;
  logic [7:0]  r_sync_byte     = RST_SYNC_BYTE;
  logic [15:0] r_gain          = RST_GAIN;

  // Framer state as the model tracks it
  logic [7:0]    cur_tick = '0;
  logic [7:0]    cur_sends = '0;
  logic          in_second_period = 1'b0;
  logic [SW-2:0] pk_x = '0;
  logic [SW-2:0] pk_y = '0;
  logic [31:0]   acc_x = '0;
  logic [31:0]   acc_y = '0;
  logic [7:0]    frame_mem [0:FRAME_LENGTH-2];

  vibration_peak_average_framer_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .sample_x   (sample_x),
    .sample_y   (sample_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .ninth_bit  (ninth_bit),
    .last_byte  (last_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 2 ns period: high half, then low half
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Fold a raw reading around mid-scale: the upper half mirrors down.
  function automatic logic [SW-2:0] fold_sample(input logic [SW-1:0] raw);
    logic [SW-1:0] half;
    half = {1'b0, {(SW-1){1'b1}}};
    if (raw > half)
      return (SW-1)'({SW{1'b1}} - raw);
    return (SW-1)'(raw);
  endfunction

  // Apply the Q0.16 gain and clamp the result to one byte.
  function automatic logic [7:0] gain_byte(input logic [31:0] v);
    logic [63:0] p;
    p = (64'(v) * 64'(r_gain)) >> 16;
    return (p > 64'd255) ? 8'hFF : p[7:0];
  endfunction

  // Queue the seven bytes of the stored frame and advance the send count.
  task automatic queue_frame();
    frame_beat_t b;
    for (int k = 0; k < FRAME_LENGTH; k++) begin
      b.data  = (k == 0) ? r_sync_byte : frame_mem[k-1];
      b.first = (k == 0);
      b.last  = (k == FRAME_LENGTH - 1);
      frame_bytes_due.push_back(b);
    end
    cur_sends = cur_sends + 8'd1;
    if (cur_sends > r_attempt_limit) begin
      // Too many sends: clear attempts and stay on the second period for good
      cur_sends = '0;
      in_second_period = 1'b1;
    end
  endtask

  // Advance the model by one accepted input transaction.
  task automatic advance_framer(input logic kind, input logic [SW-1:0] sx,
                                input logic [SW-1:0] sy);
    logic [SW-2:0] fx, fy;
    logic [7:0] b1, b2, b3, b4, limit, bsum;
    logic [31:0] avg_x, avg_y;
    int sh;
    if (kind == ITEM_SAMPLE) begin
      fx = fold_sample(sx);
      fy = fold_sample(sy);
      if (fx > pk_x) pk_x = fx;
      if (fy > pk_y) pk_y = fy;
      acc_x = acc_x + 32'(fx);
      acc_y = acc_y + 32'(fy);
    end else begin
      cur_tick = cur_tick + 8'd1;
      limit = in_second_period ? r_second_period : r_first_period;
      if (cur_tick > limit) begin
        // Period end: latch, clear and build a fresh frame
        sh    = in_second_period ? SHIFT_SECOND : SHIFT_FIRST;
        avg_x = (acc_x >> sh) / 32'(AVG_DIVISOR);
        avg_y = (acc_y >> sh) / 32'(AVG_DIVISOR);
        b1 = gain_byte(avg_x);
        b2 = gain_byte(32'(pk_x));
        b3 = gain_byte(avg_y);
        b4 = gain_byte(32'(pk_y));
        cur_tick = '0;
        pk_x = '0;
        pk_y = '0;
        acc_x = '0;
        acc_y = '0;
        bsum = b1 + b2 + b3 + b4;
        frame_mem[0] = b1;
        frame_mem[1] = b2;
        frame_mem[2] = b3;
        frame_mem[3] = b4;
        frame_mem[4] = ~bsum;
        frame_mem[5] = ~(b1 ^ b2 ^ b3 ^ b4);
        queue_frame();
      end else if (cur_sends != 8'd0 &&
                   (int'(cur_tick) == int'(r_resend_gap) ||
                    int'(cur_tick) == 2 * int'(r_resend_gap))) begin
        // Resend the stored frame at the gap tick and at twice it
        queue_frame();
      end
    end
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%s", msg);
  endtask

  // Input driver: hold valid until the transaction, then idle at random.
  always @(posedge clk) begin : drive
    stim_item_t nxt;
    logic holding;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      holding = in_valid && !in_ready;
      if (in_valid && in_ready)
        advance_framer(mode, sample_x, sample_y);
      if (!holding) begin
        if (item_queue.size() != 0 && (steady || $urandom_range(99) >= 22)) begin
          nxt = item_queue.pop_front();
          in_valid <= 1'b1;
          mode     <= nxt.kind;
          sample_x <= nxt.sx;
          sample_y <= nxt.sy;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check every transaction, stall ready at random.
  always @(posedge clk) begin : monitor
    frame_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected frame byte %02h ninth %0b last %0b",
                                  frame_byte, ninth_bit, last_byte));
        end else begin
          want = frame_bytes_due.pop_front();
          if (frame_byte !== want.data || ninth_bit !== want.first ||
              last_byte !== want.last)
            flag_mismatch($sformatf(
              "frame byte: expected %02h ninth %0b last %0b, got %02h ninth %0b last %0b",
              want.data, want.first, want.last, frame_byte, ninth_bit, last_byte));
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 22);
    end
  end

  // Watchdog: end the run when no channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("vibration_peak_average_framer_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write one register; lower valid after the transaction.
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FIRST_PERIOD:  r_first_period  = value[7:0];
      CFG_SECOND_PERIOD: r_second_period = value[7:0];
      CFG_RESEND_GAP:    r_resend_gap    = value[6:0];
      CFG_ATTEMPT_LIMIT: r_attempt_limit = value[7:0];
      CFG_SYNC_BYTE:     r_sync_byte     = value[7:0];
      CFG_GAIN:          r_gain          = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Load every register; upper bits beyond a register's width get dropped.
  task automatic configure(input logic [15:0] fp, input logic [15:0] sp,
                           input logic [15:0] gap, input logic [15:0] lim,
                           input logic [15:0] sb, input logic [15:0] g);
    write_reg(CFG_FIRST_PERIOD, fp);
    write_reg(CFG_SECOND_PERIOD, sp);
    write_reg(CFG_RESEND_GAP, gap);
    write_reg(CFG_ATTEMPT_LIMIT, lim);
    write_reg(CFG_SYNC_BYTE, sb);
    write_reg(CFG_GAIN, g);
  endtask

  task automatic add_item(input item_kind_t kind, input logic [SW-1:0] sx,
                          input logic [SW-1:0] sy);
    stim_item_t it;
    it.kind = kind;
    it.sx   = sx;
    it.sy   = sy;
    item_queue.push_back(it);
  endtask

  // Random mix of ticks and samples; some samples sit on the fold edges.
  task automatic add_random(input int count, input int tick_pct);
    logic [SW-1:0] edges [4];
    logic [SW-1:0] sx, sy;
    edges = '{12'h000, 12'h7FF, 12'h800, 12'hFFF};
    for (int i = 0; i < count; i++) begin
      sx = SW'($urandom);
      sy = SW'($urandom);
      if ($urandom_range(7) == 0) sx = edges[$urandom_range(3)];
      if ($urandom_range(7) == 0) sy = edges[$urandom_range(3)];
      add_item(($urandom_range(99) < tick_pct) ? ITEM_TICK : ITEM_SAMPLE, sx, sy);
    end
  endtask

  // Hold until the driver is drained and every frame byte is in, then settle.
  task automatic wait_idle();
    while (item_queue.size() != 0 || in_valid || frame_bytes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: fold edges, full gain, resend at the gap and twice the gap.
    // Keep the attempt limit at its top so the first period stays in force.
    configure(16'd3, 16'd0, 16'd1, 16'd255, 16'd0, 16'hFFFF);
    write_reg(CFG_SPARE_6, 16'hFFFF);
    write_reg(CFG_SPARE_7, 16'h0000);
    add_item(ITEM_SAMPLE, 12'h000, 12'hFFF);
    add_item(ITEM_SAMPLE, 12'h7FF, 12'h800);
    add_item(ITEM_SAMPLE, 12'hFFF, 12'h7FF);
    add_item(ITEM_SAMPLE, 12'h800, 12'h000);
    repeat (4) add_item(ITEM_TICK, 12'h000, 12'h000);   // fourth one ends the period
    repeat (4) add_item(ITEM_TICK, 12'hFFF, 12'hFFF);   // resend, resend, none, frame
    wait_idle();

    // Directed: period end on twice the gap must send a single frame.
    configure(16'd3, 16'd0, 16'd2, 16'd255, 16'd255, 16'd1);
    add_item(ITEM_SAMPLE, 12'h555, 12'hAAA);
    add_item(ITEM_SAMPLE, 12'hAAA, 12'h555);
    add_item(ITEM_SAMPLE, 12'hABC, 12'h543);
    repeat (4) add_item(ITEM_TICK, 12'h000, 12'h000);
    wait_idle();

    // Random, first period, short periods and random gain
    configure(16'($urandom_range(12, 2)), 16'($urandom), 16'($urandom_range(6)),
              16'd255, 16'($urandom), 16'($urandom));
    add_random(20, 50);
    wait_idle();

    // Random, a frame on every tick with no idling
    steady = 1'b1;
    configure(16'd0, 16'd0, 16'd127, 16'd255, 16'($urandom), 16'($urandom));
    add_random(30, 97);
    wait_idle();
    steady = 1'b0;

    // Random, attempt limit zero: the next send switches to the second period
    configure(16'($urandom_range(8, 2)), 16'($urandom_range(8)),
              16'($urandom_range(4, 1)), 16'd0, 16'd255, 16'hFFFF);
    add_random(30, 50);
    wait_idle();

    // Random, second period, junk in the unused upper data bits
    configure(16'($urandom), 16'($urandom_range(20, 3)), 16'($urandom),
              16'($urandom_range(4)), 16'($urandom), 16'($urandom));
    add_random(30, 45);
    wait_idle();

    // Random, period at its top: no frame fires, the tick count wraps
    configure(16'($urandom), 16'd255, 16'd0, 16'd255, 16'($urandom), 16'($urandom));
    add_random(262, 99);
    wait_idle();

    // Random, gain zero with a resend between frames
    configure(16'($urandom), 16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
    add_random(20, 70);
    wait_idle();

    if (mismatches == 0 && frame_bytes_due.size() == 0) begin
      $display("vibration_peak_average_framer_top: match");
    end else begin
      $display("vibration_peak_average_framer_top: mismatch");
    end
    $finish;
  end

endmodule
